>>> hw/rtl/ncc_pkg.sv
// ============================================================================
// ncc_pkg
// Shared types, constants and saturation helpers for the NLMS canceller.
// ============================================================================
`default_nettype none

package ncc_pkg;

  localparam int TAP_COUNT_DEF    = 16;
  localparam int NUM_CHANNELS_DEF = 4;
  localparam int FIELD_CHANNELS   = 4;

  localparam int SAMPLE_W = 16;
  localparam int WEIGHT_W = 32;
  localparam int CFG_W    = 32;
  localparam int CFG_IDX_W = 2;
  localparam int TAPS_W   = 5;

  localparam int QUOT_W   = 33;
  localparam int NUM_W    = 60;
  localparam int PWR_BASE = 33;
  localparam int ACC_BASE = 49;

  localparam logic [CFG_IDX_W-1:0] REG_STEP_SIZE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REGULARIZ = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TAPS      = 2'd2;

  localparam logic [15:0]       STEP_SIZE_RST = 16'd6554;
  localparam logic [31:0]       REGULARIZ_RST = 32'd1074;
  localparam logic [TAPS_W-1:0] TAPS_RST      = 5'd16;

  typedef struct packed {
    logic start;
    logic rd;
    logic prod;
    logic acc;
    logic err;
    logic upd_u;
    logic upd_n;
    logic upd_chk;
    logic upd_div;
    logic upd_wr;
    logic clr;
  } lane_ctl_t;

  function automatic logic signed [15:0] sat16(input logic signed [63:0] v);
    logic signed [15:0] r;
    if (v > 64'sd32767) r = 16'sh7fff;
    else if (v < -64'sd32768) r = 16'sh8000;
    else r = v[15:0];
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) r = 32'sh7fffffff;
    else if (v < -64'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/ncc_ram.sv
// ============================================================================
// ncc_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
`default_nettype none

module ncc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/ncc_lane.sv
// ============================================================================
// ncc_lane
// One channel lane: clutter estimate MAC, error, and NLMS weight update.
// ============================================================================
`default_nettype none

module ncc_lane #(
  parameter int TAP_COUNT = ncc_pkg::TAP_COUNT_DEF,
  localparam int TW = (TAP_COUNT > 1) ? $clog2(TAP_COUNT) : 1,
  localparam int LW = $clog2(TAP_COUNT + 1),
  localparam int PW = ncc_pkg::PWR_BASE + $clog2(TAP_COUNT + 1)
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire ncc_pkg::lane_ctl_t  ctl_i,
  input  wire logic [TW-1:0]       tap_i,
  input  wire logic [LW-1:0]       clr_len_i,
  input  wire logic signed [15:0]  surv_re_i,
  input  wire logic signed [15:0]  surv_im_i,
  input  wire logic signed [15:0]  ref_re_i,
  input  wire logic signed [15:0]  ref_im_i,
  input  wire logic [15:0]         mu_i,
  input  wire logic [PW-1:0]       pw_i,
  output logic signed [15:0]       err_re_o,
  output logic signed [15:0]       err_im_o
);

  localparam int AW = ncc_pkg::ACC_BASE + $clog2(TAP_COUNT + 1);
  localparam int QW = ncc_pkg::QUOT_W;
  localparam int NW = ncc_pkg::NUM_W;
  localparam int CW = PW + QW;
  localparam int DW = QW + 3;
  localparam logic signed [AW:0] RND = signed'((AW+1)'(1) << 26);

  logic [63:0]          w_rdata;
  logic                 w_vld_q;
  logic [TAP_COUNT-1:0] vld_q;
  logic signed [31:0]   w_re, w_im;
  logic signed [31:0]   w_re_q, w_im_q, wn_re, wn_im;

  logic signed [47:0]   p_rr_q, p_ii_q, p_ri_q, p_ir_q;
  logic signed [AW-1:0] acc_re_q, acc_im_q;
  logic signed [15:0]   surv_re_q, surv_im_q;
  logic signed [AW:0]   e_re, e_im, e_re_sh, e_im_sh;

  logic signed [31:0]   a_q, b_q, c_q, d_q;
  logic signed [32:0]   u_re, u_im, u_re_n, u_im_n;
  logic [31:0]          mag_re, mag_im;
  logic [47:0]          mm_re, mm_im;
  logic [NW-1:0]        num_re_q, num_im_q;
  logic                 neg_re_q, neg_im_q, sat_re_q, sat_im_q;
  logic [CW-1:0]        rem_re_q, rem_im_q, dv_q;
  logic [QW-1:0]        q_re_q, q_im_q;
  logic [QW:0]          dm_re, dm_im;
  logic signed [DW-1:0] ds_re, ds_im, ws_re, ws_im;

  ncc_ram #(.WIDTH(64), .DEPTH(TAP_COUNT)) u_wram (
    .clk_i  (clk_i),
    .we_i   (ctl_i.upd_wr),
    .waddr_i(tap_i),
    .wdata_i({wn_im, wn_re}),
    .re_i   (ctl_i.rd),
    .raddr_i(tap_i),
    .rdata_o(w_rdata)
  );

  assign w_re = w_vld_q ? signed'(w_rdata[31:0])  : '0;
  assign w_im = w_vld_q ? signed'(w_rdata[63:32]) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q   <= '0;
      w_vld_q <= 1'b0;
    end else begin
      if (ctl_i.rd) begin
        w_vld_q <= vld_q[tap_i];
      end
      for (int i = 0; i < TAP_COUNT; i++) begin
        if (ctl_i.clr && (LW'(i) >= clr_len_i)) begin
          vld_q[i] <= 1'b0;
        end
      end
      if (ctl_i.upd_wr) begin
        vld_q[tap_i] <= 1'b1;
      end
    end
  end

  assign e_re    = ((AW+1)'(surv_re_q) <<< 27) - (AW+1)'(acc_re_q) + RND;
  assign e_im    = ((AW+1)'(surv_im_q) <<< 27) - (AW+1)'(acc_im_q) + RND;
  assign e_re_sh = e_re >>> 27;
  assign e_im_sh = e_im >>> 27;

  assign u_re   = 33'(a_q) + 33'(b_q);
  assign u_im   = 33'(c_q) - 33'(d_q);
  assign u_re_n = -u_re;
  assign u_im_n = -u_im;
  assign mag_re = u_re[32] ? u_re_n[31:0] : u_re[31:0];
  assign mag_im = u_im[32] ? u_im_n[31:0] : u_im[31:0];
  assign mm_re  = mag_re * mu_i;
  assign mm_im  = mag_im * mu_i;

  assign dm_re = sat_re_q ? ((QW+1)'(1) << QW) : {1'b0, q_re_q};
  assign dm_im = sat_im_q ? ((QW+1)'(1) << QW) : {1'b0, q_im_q};
  assign ds_re = neg_re_q ? -signed'(DW'(dm_re)) : signed'(DW'(dm_re));
  assign ds_im = neg_im_q ? -signed'(DW'(dm_im)) : signed'(DW'(dm_im));
  assign ws_re = DW'(w_re_q) + ds_re;
  assign ws_im = DW'(w_im_q) + ds_im;
  assign wn_re = ncc_pkg::sat32(64'(ws_re));
  assign wn_im = ncc_pkg::sat32(64'(ws_im));

  always_ff @(posedge clk_i) begin
    if (ctl_i.start) begin
      surv_re_q <= surv_re_i;
      surv_im_q <= surv_im_i;
      acc_re_q  <= '0;
      acc_im_q  <= '0;
    end
    if (ctl_i.prod) begin
      p_rr_q <= w_re * ref_re_i;
      p_ii_q <= w_im * ref_im_i;
      p_ri_q <= w_re * ref_im_i;
      p_ir_q <= w_im * ref_re_i;
    end
    if (ctl_i.acc) begin
      acc_re_q <= acc_re_q + AW'(p_rr_q) - AW'(p_ii_q);
      acc_im_q <= acc_im_q + AW'(p_ri_q) + AW'(p_ir_q);
    end
    if (ctl_i.err) begin
      err_re_o <= ncc_pkg::sat16(64'(e_re_sh));
      err_im_o <= ncc_pkg::sat16(64'(e_im_sh));
    end
    if (ctl_i.upd_u) begin
      w_re_q <= w_re;
      w_im_q <= w_im;
      a_q    <= err_re_o * ref_re_i;
      b_q    <= err_im_o * ref_im_i;
      c_q    <= err_im_o * ref_re_i;
      d_q    <= err_re_o * ref_im_i;
    end
    if (ctl_i.upd_n) begin
      neg_re_q <= u_re[32];
      neg_im_q <= u_im[32];
      num_re_q <= NW'({mm_re, 11'b0}) + NW'(pw_i >> 1);
      num_im_q <= NW'({mm_im, 11'b0}) + NW'(pw_i >> 1);
    end
    if (ctl_i.upd_chk) begin
      sat_re_q <= CW'(num_re_q) >= (CW'(pw_i) << QW);
      sat_im_q <= CW'(num_im_q) >= (CW'(pw_i) << QW);
      rem_re_q <= CW'(num_re_q);
      rem_im_q <= CW'(num_im_q);
      dv_q     <= CW'(pw_i) << (QW - 1);
      q_re_q   <= '0;
      q_im_q   <= '0;
    end
    if (ctl_i.upd_div) begin
      dv_q <= dv_q >> 1;
      if (rem_re_q >= dv_q) begin
        rem_re_q <= rem_re_q - dv_q;
        q_re_q   <= {q_re_q[QW-2:0], 1'b1};
      end else begin
        q_re_q   <= {q_re_q[QW-2:0], 1'b0};
      end
      if (rem_im_q >= dv_q) begin
        rem_im_q <= rem_im_q - dv_q;
        q_im_q   <= {q_im_q[QW-2:0], 1'b1};
      end else begin
        q_im_q   <= {q_im_q[QW-2:0], 1'b0};
      end
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/complex_nlms_clutter_canceller_top.sv
// ============================================================================
// complex_nlms_clutter_canceller_top
// Multi-channel complex NLMS clutter canceller with a shared reference line.
// ============================================================================
//
//  channel   direction  transaction payload
//  s_axis    in         ref, surv0..surv3 (complex Q1.15)
//  m_axis    out        out0..out3 (complex Q1.15 error)
//  cfg       in         step_size, regularization, taps_in_use
//
//  One transaction, L the active tap count, runs an estimate pass over the L
//  taps, then per tap a weight update with a radix-2 divider in every lane.
//  All channel lanes run in lockstep.
//  Reset is asynchronous; delay line and weights read as zero until written.
//  A result waits in the output register while the next item is processed.
`default_nettype none

module complex_nlms_clutter_canceller_top #(
  parameter int TAP_COUNT    = ncc_pkg::TAP_COUNT_DEF,
  parameter int NUM_CHANNELS = ncc_pkg::NUM_CHANNELS_DEF
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // ref_re, ref_im, surv0_re, surv0_im, .. surv3_re, surv3_im
  input  wire logic [159:0] s_axis_tdata,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // out0_re, out0_im, .. out3_re, out3_im
  output logic [127:0]      m_axis_tdata,
  input  wire logic         cfg_we_i,
  input  wire logic [ncc_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [ncc_pkg::CFG_W-1:0]     cfg_data_i
);

  localparam int TW = (TAP_COUNT > 1) ? $clog2(TAP_COUNT) : 1;
  localparam int LW = $clog2(TAP_COUNT + 1);
  localparam int PW = ncc_pkg::PWR_BASE + $clog2(TAP_COUNT + 1);
  localparam int QW = ncc_pkg::QUOT_W;
  localparam int NLANE = (NUM_CHANNELS < ncc_pkg::FIELD_CHANNELS) ?
                         NUM_CHANNELS : ncc_pkg::FIELD_CHANNELS;

  typedef enum logic [3:0] {
    ST_IDLE, ST_EST, ST_EDRN, ST_ERR, ST_URD, ST_UU, ST_UN, ST_UCHK,
    ST_UDIV, ST_UWR, ST_OUT
  } state_e;

  state_e                       state_q;
  logic [15:0]                  mu_q;
  logic [31:0]                  eps_q;
  logic [ncc_pkg::TAPS_W-1:0]   tiu_q;
  logic [TW-1:0]                h_q, h_n;
  logic [LW-1:0]                k_q, l_act, l_new;
  logic [5:0]                   cnt_q;
  logic                         prod_q, acc_q;
  logic [TAP_COUNT-1:0]         lvld_q;
  logic                         lv_q;
  logic [31:0]                  line_rdata;
  logic [TW:0]                  la_diff, la;
  logic signed [15:0]           ref_re, ref_im;
  logic [31:0]                  sq_q;
  logic [PW-1:0]                pw_q;
  logic                         accept, rd;
  ncc_pkg::lane_ctl_t           ctl;
  logic signed [15:0]           err_re [ncc_pkg::FIELD_CHANNELS];
  logic signed [15:0]           err_im [ncc_pkg::FIELD_CHANNELS];

  function automatic logic [LW-1:0] clamp_taps(input logic [ncc_pkg::TAPS_W-1:0] t);
    logic [LW-1:0] r;
    if (t == '0) r = LW'(1);
    else if (32'(t) > 32'(TAP_COUNT)) r = LW'(TAP_COUNT);
    else r = LW'(t);
    return r;
  endfunction

  assign l_act  = clamp_taps(tiu_q);
  assign l_new  = clamp_taps(cfg_data_i[ncc_pkg::TAPS_W-1:0]);
  assign accept = s_axis_tvalid && s_axis_tready;
  assign rd     = (state_q == ST_EST) || (state_q == ST_URD);
  assign h_n    = (h_q == TW'(TAP_COUNT - 1)) ? '0 : h_q + 1'b1;

  assign la_diff = {1'b0, h_q} - {1'b0, k_q[TW-1:0]};
  assign la      = la_diff[TW] ? la_diff + (TW+1)'(TAP_COUNT) : la_diff;

  assign s_axis_tready = (state_q == ST_IDLE);

  ncc_ram #(.WIDTH(32), .DEPTH(TAP_COUNT)) u_line (
    .clk_i  (clk_i),
    .we_i   (accept),
    .waddr_i(h_n),
    .wdata_i(s_axis_tdata[31:0]),
    .re_i   (rd),
    .raddr_i(la[TW-1:0]),
    .rdata_o(line_rdata)
  );

  assign ref_re = lv_q ? signed'(line_rdata[15:0])  : '0;
  assign ref_im = lv_q ? signed'(line_rdata[31:16]) : '0;

  always_comb begin
    ctl         = '0;
    ctl.start   = accept;
    ctl.rd      = rd;
    ctl.prod    = prod_q;
    ctl.acc     = acc_q;
    ctl.err     = (state_q == ST_ERR);
    ctl.upd_u   = (state_q == ST_UU);
    ctl.upd_n   = (state_q == ST_UN);
    ctl.upd_chk = (state_q == ST_UCHK);
    ctl.upd_div = (state_q == ST_UDIV);
    ctl.upd_wr  = (state_q == ST_UWR);
    ctl.clr     = cfg_we_i && (cfg_idx_i == ncc_pkg::REG_TAPS);
  end

  for (genvar c = 0; c < ncc_pkg::FIELD_CHANNELS; c++) begin : g_lane
    if (c < NLANE) begin : g_on
      ncc_lane #(.TAP_COUNT(TAP_COUNT)) u_lane (
        .clk_i    (clk_i),
        .rst_ni   (rst_ni),
        .ctl_i    (ctl),
        .tap_i    (k_q[TW-1:0]),
        .clr_len_i(l_new),
        .surv_re_i(signed'(s_axis_tdata[32 + 32*c +: 16])),
        .surv_im_i(signed'(s_axis_tdata[48 + 32*c +: 16])),
        .ref_re_i (ref_re),
        .ref_im_i (ref_im),
        .mu_i     (mu_q),
        .pw_i     (pw_q),
        .err_re_o (err_re[c]),
        .err_im_o (err_im[c])
      );
    end else begin : g_off
      assign err_re[c] = '0;
      assign err_im[c] = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (prod_q) begin
      sq_q <= 32'(ref_re * ref_re) + 32'(ref_im * ref_im);
    end
    if (accept) begin
      pw_q <= PW'(eps_q);
    end else if (acc_q) begin
      pw_q <= pw_q + PW'(sq_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      mu_q          <= ncc_pkg::STEP_SIZE_RST;
      eps_q         <= ncc_pkg::REGULARIZ_RST;
      tiu_q         <= ncc_pkg::TAPS_RST;
      h_q           <= '0;
      k_q           <= '0;
      cnt_q         <= '0;
      prod_q        <= 1'b0;
      acc_q         <= 1'b0;
      lvld_q        <= '0;
      lv_q          <= 1'b0;
      m_axis_tvalid <= 1'b0;
      m_axis_tdata  <= '0;
    end else begin
      prod_q <= (state_q == ST_EST);
      acc_q  <= prod_q;
      if (rd) begin
        lv_q <= lvld_q[la[TW-1:0]];
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          ncc_pkg::REG_STEP_SIZE: mu_q  <= cfg_data_i[15:0];
          ncc_pkg::REG_REGULARIZ: eps_q <= cfg_data_i;
          ncc_pkg::REG_TAPS:      tiu_q <= cfg_data_i[ncc_pkg::TAPS_W-1:0];
          default: ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready && (state_q != ST_OUT)) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            h_q         <= h_n;
            lvld_q[h_n] <= 1'b1;
            k_q         <= '0;
            state_q     <= ST_EST;
          end
        end
        ST_EST: begin
          k_q <= k_q + 1'b1;
          if (LW'(k_q + 1'b1) == l_act) begin
            state_q <= ST_EDRN;
          end
        end
        ST_EDRN: begin
          if (!prod_q && !acc_q) begin
            state_q <= ST_ERR;
          end
        end
        ST_ERR: begin
          k_q <= '0;
          if (pw_q == '0) begin
            state_q <= ST_OUT;
          end else begin
            state_q <= ST_URD;
          end
        end
        ST_URD:  state_q <= ST_UU;
        ST_UU:   state_q <= ST_UN;
        ST_UN:   state_q <= ST_UCHK;
        ST_UCHK: begin
          cnt_q   <= '0;
          state_q <= ST_UDIV;
        end
        ST_UDIV: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == 6'(QW - 1)) begin
            state_q <= ST_UWR;
          end
        end
        ST_UWR: begin
          k_q <= k_q + 1'b1;
          if (LW'(k_q + 1'b1) == l_act) begin
            state_q <= ST_OUT;
          end else begin
            state_q <= ST_URD;
          end
        end
        ST_OUT: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            for (int c = 0; c < ncc_pkg::FIELD_CHANNELS; c++) begin
              m_axis_tdata[32*c +: 16]      <= err_re[c];
              m_axis_tdata[16 + 32*c +: 16] <= err_im[c];
            end
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/ncc_checker.sv
// ============================================================================
// ncc_checker
// Port-level checks for the NLMS canceller, bound to the top level.
// ============================================================================
`default_nettype none

module ncc_checker (
  input wire logic         clk_i,
  input wire logic         rst_ni,
  input wire logic         s_axis_tvalid,
  input wire logic         s_axis_tready,
  input wire logic         m_axis_tvalid,
  input wire logic         m_axis_tready,
  input wire logic [127:0] m_axis_tdata
);

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input accepted while previous transaction in flight");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled output transaction changed");

  a_out_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result appeared without a transaction in progress");

endmodule

bind complex_nlms_clutter_canceller_top ncc_checker u_ncc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);

`default_nettype wire
